// ===== sv/ipc_pkg.sv =====
package ipc_pkg;

  // Fixed field widths.
  localparam int MASS_W    = 44;
  localparam int AB_W      = 32;
  localparam int ATOM_W    = 20;
  localparam int ISO_CNT_W = 4;
  localparam int NUM_PK_W  = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // The divisor holds a peak's total abundance: at most 64 terms below 2^32.
  localparam int DIV_W = 38;
  localparam int NUM_W = DIV_W + MASS_W;

  localparam logic [MASS_W-1:0] MASS_MAX     = {MASS_W{1'b1}};
  localparam logic [MASS_W-1:0] ELECTRON_Q24 = 44'd9204;

  // Commands.
  localparam logic [1:0] CMD_LOAD_ISOTOPE = 2'd0;
  localparam logic [1:0] CMD_LOAD_ELEMENT = 2'd1;
  localparam logic [1:0] CMD_RUN          = 2'd2;

  // Run status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_TRUNC = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PRUNE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE      = 2'd1;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [2:0]           element_index;
    logic [2:0]           isotope_index;
    logic [MASS_W-1:0]    isotope_mass;
    logic [AB_W-1:0]      isotope_abundance;
    logic [ATOM_W-1:0]    atom_count;
    logic [ISO_CNT_W-1:0] isotope_count;
  } in_item_t;

  typedef struct packed {
    logic [MASS_W-1:0]   peak_mass;
    logic [AB_W-1:0]     peak_abundance;
    logic [NUM_PK_W-1:0] peak_number;
    logic [1:0]          run_status;
    logic                last_peak;
  } out_item_t;

  // One stage of the divider chain: partial remainder, dividend bits that
  // still have to enter on the left and quotient bits collected on the right.
  typedef struct packed {
    logic              valid;
    logic [DIV_W-1:0]  rem;
    logic [MASS_W-1:0] work;
    logic [DIV_W-1:0]  den;
  } div_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ELEM_START,
    ST_TCOPY,
    ST_BIT,
    ST_SQCHK,
    ST_CONV_SETUP,
    ST_CONV_K,
    ST_CONV_RD,
    ST_CONV_MUL,
    ST_CONV_MUL2,
    ST_CONV_ACC,
    ST_CONV_DIV,
    ST_CONV_DIVW,
    ST_SCOPY,
    ST_PSETUP,
    ST_PCOPY,
    ST_OUT_START,
    ST_OUT_RD,
    ST_OUT_CALC,
    ST_OUT_DIVW,
    ST_OUT_EMIT,
    ST_OUT_EMPTY
  } state_t;

endpackage

// ===== sv/ipc_div_cell.sv =====
module ipc_div_cell import ipc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  div_t din,
  output div_t dout
);

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;

  // One restoring step: bring in the next dividend bit and try the divisor.
  always_comb begin
    trial = {din.rem, din.work[MASS_W-1]};
    diff  = trial - {1'b0, din.den};
    ge    = (trial >= {1'b0, din.den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.rem  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    dout.work <= {din.work[MASS_W-2:0], ge};
    dout.den  <= din.den;
  end

endmodule

// ===== sv/ipc_div_chain.sv =====
module ipc_div_chain import ipc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  div_t issue,
  output div_t result
);

  div_t stage [MASS_W+1];

  assign stage[0] = issue;

  // One cell per quotient bit; the quotient leaves the last cell in work.
  for (genvar c = 0; c < MASS_W; c++) begin : g_cell
    ipc_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (stage[c]),
      .dout (stage[c+1])
    );
  end

  assign result = stage[MASS_W];

endmodule

// ===== sv/isotope_pattern_convolver.sv =====
// Isotope pattern convolver.
// Input channel (in_valid / in_stall / in_item): load items write an isotope
// entry or an element's atom and isotope counts and do not raise in_stall. A run
// item computes the molecule's peak list; in_stall stays high until the last
// peak of the run has been placed in the output register.
// Output channel (out_valid / out_stall / out_item): one item per peak, with
// last_peak on the final one; an empty result gives a single item.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always ready.
// A run forms, for every convolution, the abundance products of each output
// peak and divides for its mean mass in the 44-cell divider chain, then
// copies the pruned peaks; an emitted peak with nonzero abundance passes
// the chain again when a charge is set. Square-and-multiply makes at most
// two convolutions per bit of each atom count.
// Reset sets the configuration registers and clears the sequencer state, the
// atom and isotope counts and the output valid; the isotope tables hold no
// defined value until loaded. While the receiver stalls, the pending peak
// stays in the output register and the run waits to emit the next one.
module isotope_pattern_convolver import ipc_pkg::*; #(
  parameter int ELEMENTS  = 8,
  parameter int ISOTOPES  = 8,
  parameter int MAX_PEAKS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int EIW    = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int ECW    = $clog2(ELEMENTS + 1);
  localparam int CW     = $clog2(ISOTOPES + 1);
  localparam int TDEPTH = ELEMENTS * ISOTOPES;
  localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int PAW    = $clog2(MAX_PEAKS);
  localparam int LW     = $clog2(MAX_PEAKS + 1);

  state_t state, state_next;

  // Configuration registers.
  logic [AB_W-1:0]   prune_limit;
  logic signed [4:0] charge_state;

  // Element counts.
  logic [ATOM_W-1:0] atoms   [ELEMENTS];
  logic [CW-1:0]     iso_cnt [ELEMENTS];

  // Memories.
  logic [MASS_W-1:0] tab_mass  [TDEPTH];
  logic [AB_W-1:0]   tab_ab    [TDEPTH];
  logic [MASS_W-1:0] elem_mass [MAX_PEAKS];
  logic [AB_W-1:0]   elem_ab   [MAX_PEAKS];
  logic [MASS_W-1:0] mol_mass  [MAX_PEAKS];
  logic [AB_W-1:0]   mol_ab    [MAX_PEAKS];
  logic [MASS_W-1:0] scr_mass  [MAX_PEAKS];
  logic [AB_W-1:0]   scr_ab    [MAX_PEAKS];

  logic [MASS_W-1:0] tab_m_q, elem_m_a, elem_m_b, mol_m_q, scr_m_q;
  logic [AB_W-1:0]   tab_ab_q, elem_ab_a, elem_ab_b, mol_ab_q, scr_ab_q;

  // Sequencer registers.
  logic [ECW-1:0]    e_cnt;
  logic [ATOM_W-1:0] n_left;
  logic              seeded;
  logic              trunc;
  logic              conv_sq;
  logic              dest_elem;
  logic [LW-1:0]     mlen, elen, slen;
  logic [LW-1:0]     cj, cn;
  logic              wpend;
  logic [PAW-1:0]    wa;
  logic [LW-1:0]     k, i_idx, hi_idx;
  logic [AB_W-1:0]   p_q;
  logic [MASS_W-1:0] ms_q;
  logic [53:0]       plo, phi;
  logic [NUM_W-1:0]  acc;
  logic [DIV_W-1:0]  total;
  logic              found;
  logic [PAW-1:0]    first, last;
  logic [MASS_W-1:0] pk_mass;
  logic [AB_W-1:0]   pk_ab;

  // Combinational signals.
  logic              accept;
  logic              ei_ok, ii_ok;
  logic [TAW-1:0]    tab_waddr, tab_raddr;
  logic [PAW-1:0]    elem_raddr_a, elem_raddr_b, mol_raddr, scr_raddr;
  logic [EIW-1:0]    e_sel;
  logic [CW-1:0]     cnt_sel;
  logic              cnt_trunc;
  logic [LW-1:0]     cnt_eff;
  logic [LW-1:0]     n1, n2;
  logic [LW:0]       full, kp1;
  logic              full_trunc;
  logic [LW-1:0]     lo, hi;
  logic [LW-1:0]     plen;
  logic              copy_issue, copy_done;
  logic [AB_W-1:0]   a1;
  logic [MASS_W-1:0] m1;
  logic [63:0]       prod64;
  logic [MASS_W:0]   msum;
  logic [NUM_W-1:0]  acc_add, num_mean, num_chg;
  logic [AB_W-1:0]   ab_sat;
  logic [4:0]        zabs;
  logic [MASS_W-1:0] q, adj;
  logic [MASS_W:0]   qsum;
  logic              out_free, last_out;
  logic              emit_load;
  logic              elem_we, mol_we, scr_we;
  logic [PAW-1:0]    elem_wa, scr_wa;
  logic [MASS_W-1:0] elem_wm, scr_wm;
  logic [AB_W-1:0]   elem_wab, scr_wab;
  div_t              div_in, div_out;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      prune_limit  <= 32'd429497;
      charge_state <= 5'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PRUNE_LIMIT: prune_limit  <= cfg_data[AB_W-1:0];
        REG_CHARGE:      charge_state <= signed'(cfg_data[4:0]);
        default: ;
      endcase
    end
  end

  // Load decoding.
  always_comb begin
    ei_ok     = int'(in_item.element_index) < ELEMENTS;
    ii_ok     = int'(in_item.isotope_index) < ISOTOPES;
    tab_waddr = TAW'(int'(in_item.element_index) * ISOTOPES + int'(in_item.isotope_index));
  end

  // Element counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < ELEMENTS; j++) begin
        atoms[j]   <= '0;
        iso_cnt[j] <= '0;
      end
    end else if (accept && in_item.cmd == CMD_LOAD_ELEMENT && ei_ok) begin
      atoms[EIW'(in_item.element_index)] <= in_item.atom_count;
      if (int'(in_item.isotope_count) > ISOTOPES) begin
        iso_cnt[EIW'(in_item.element_index)] <= CW'(ISOTOPES);
      end else begin
        iso_cnt[EIW'(in_item.element_index)] <= CW'(in_item.isotope_count);
      end
    end
  end

  // Element selection and list arithmetic.
  always_comb begin
    e_sel      = EIW'(e_cnt);
    cnt_sel    = iso_cnt[e_sel];
    cnt_trunc  = int'(cnt_sel) > MAX_PEAKS;
    cnt_eff    = cnt_trunc ? LW'(MAX_PEAKS) : LW'(cnt_sel);
    n1         = conv_sq ? elen : mlen;
    n2         = elen;
    full       = {1'b0, n1} + {1'b0, n2} - (LW+1)'(1);
    full_trunc = full > (LW+1)'(MAX_PEAKS);
    kp1        = {1'b0, k} + (LW+1)'(1);
    lo         = (kp1 > {1'b0, n2}) ? LW'(kp1 - {1'b0, n2}) : '0;
    hi         = (k < n1 - LW'(1)) ? k : n1 - LW'(1);
    plen       = found ? (LW'(last) - LW'(first) + LW'(1)) : '0;
    copy_issue = cj < cn;
    copy_done  = !copy_issue && !wpend;
  end

  // Read addresses.
  always_comb begin
    tab_raddr    = TAW'(int'(e_sel) * ISOTOPES + int'(cj));
    elem_raddr_a = (state == ST_SCOPY) ? PAW'(cj) : PAW'(i_idx);
    elem_raddr_b = PAW'(k - i_idx);
    mol_raddr    = (state == ST_OUT_RD || state == ST_OUT_CALC) ? PAW'(k) : PAW'(i_idx);
    scr_raddr    = PAW'(LW'(first) + cj);
  end

  // Convolution arithmetic.
  always_comb begin
    a1       = conv_sq ? elem_ab_a : mol_ab_q;
    m1       = conv_sq ? elem_m_a : mol_m_q;
    prod64   = {32'b0, a1} * {32'b0, elem_ab_b} + 64'h8000_0000;
    msum     = {1'b0, m1} + {1'b0, elem_m_b};
    acc_add  = acc + NUM_W'(plo) + (NUM_W'(phi) << 22);
    num_mean = acc + NUM_W'(total >> 1);
    ab_sat   = (|total[DIV_W-1:AB_W]) ? {AB_W{1'b1}} : total[AB_W-1:0];
  end

  // Charge adjustment.
  always_comb begin
    zabs    = charge_state[4] ? 5'(-charge_state) : 5'(charge_state);
    num_chg = NUM_W'(mol_m_q) + NUM_W'(zabs >> 1);
    q       = div_out.work;
    qsum    = {1'b0, q} + {1'b0, ELECTRON_Q24};
    if (!charge_state[4]) begin
      adj = (q > ELECTRON_Q24) ? q - ELECTRON_Q24 : '0;
    end else begin
      adj = qsum[MASS_W] ? MASS_MAX : qsum[MASS_W-1:0];
    end
    out_free  = !out_valid || !out_stall;
    last_out  = (k + LW'(1)) == mlen;
    emit_load = out_free && (state == ST_OUT_EMIT || state == ST_OUT_EMPTY);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_item.cmd == CMD_RUN) state_next = ST_ELEM_START;
      end
      ST_ELEM_START: begin
        if (e_cnt == ECW'(ELEMENTS)) state_next = ST_OUT_START;
        else if (atoms[e_sel] != '0) state_next = ST_TCOPY;
      end
      ST_TCOPY: begin
        if (copy_done) state_next = ST_BIT;
      end
      ST_BIT: begin
        if (n_left[0]) state_next = seeded ? ST_CONV_SETUP : ST_SCOPY;
        else state_next = ST_SQCHK;
      end
      ST_SQCHK: begin
        state_next = (n_left == ATOM_W'(1)) ? ST_ELEM_START : ST_CONV_SETUP;
      end
      ST_CONV_SETUP: begin
        state_next = (n1 == '0 || n2 == '0) ? ST_PSETUP : ST_CONV_K;
      end
      ST_CONV_K: begin
        state_next = (k == slen) ? ST_PSETUP : ST_CONV_RD;
      end
      ST_CONV_RD:   state_next = ST_CONV_MUL;
      ST_CONV_MUL:  state_next = ST_CONV_MUL2;
      ST_CONV_MUL2: state_next = ST_CONV_ACC;
      ST_CONV_ACC: begin
        state_next = (i_idx == hi_idx) ? ST_CONV_DIV : ST_CONV_RD;
      end
      ST_CONV_DIV: begin
        state_next = (total == '0) ? ST_CONV_K : ST_CONV_DIVW;
      end
      ST_CONV_DIVW: begin
        if (div_out.valid) state_next = ST_CONV_K;
      end
      ST_SCOPY: begin
        if (copy_done) state_next = ST_PSETUP;
      end
      ST_PSETUP: state_next = ST_PCOPY;
      ST_PCOPY: begin
        if (copy_done) state_next = dest_elem ? ST_BIT : ST_SQCHK;
      end
      ST_OUT_START: begin
        state_next = (mlen == '0) ? ST_OUT_EMPTY : ST_OUT_RD;
      end
      ST_OUT_RD: state_next = ST_OUT_CALC;
      ST_OUT_CALC: begin
        state_next = (mol_ab_q == '0 || charge_state == 5'sd0) ? ST_OUT_EMIT : ST_OUT_DIVW;
      end
      ST_OUT_DIVW: begin
        if (div_out.valid) state_next = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        if (out_free) state_next = last_out ? ST_IDLE : ST_OUT_RD;
      end
      ST_OUT_EMPTY: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs: memory writes and divider issue.
  always_comb begin
    in_stall = (state != ST_IDLE);
    elem_we  = 1'b0;
    elem_wa  = wa;
    elem_wm  = tab_m_q;
    elem_wab = tab_ab_q;
    mol_we   = 1'b0;
    scr_we   = 1'b0;
    scr_wa   = wa;
    scr_wm   = elem_m_a;
    scr_wab  = elem_ab_a;
    div_in.valid = 1'b0;
    div_in.rem   = num_mean[NUM_W-1:MASS_W];
    div_in.work  = num_mean[MASS_W-1:0];
    div_in.den   = total;
    unique case (state)
      ST_TCOPY: begin
        elem_we = wpend;
      end
      ST_SCOPY: begin
        scr_we = wpend;
      end
      ST_PCOPY: begin
        elem_we  = wpend && dest_elem;
        mol_we   = wpend && !dest_elem;
        elem_wm  = scr_m_q;
        elem_wab = scr_ab_q;
      end
      ST_CONV_DIV: begin
        scr_we       = (total == '0);
        scr_wa       = PAW'(k);
        scr_wm       = '0;
        scr_wab      = '0;
        div_in.valid = (total != '0);
      end
      ST_CONV_DIVW: begin
        scr_we  = div_out.valid;
        scr_wa  = PAW'(k);
        scr_wm  = q;
        scr_wab = ab_sat;
      end
      ST_OUT_CALC: begin
        div_in.valid = (mol_ab_q != '0) && (charge_state != 5'sd0);
        div_in.rem   = num_chg[NUM_W-1:MASS_W];
        div_in.work  = num_chg[MASS_W-1:0];
        div_in.den   = DIV_W'(zabs);
      end
      default: ;
    endcase
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (accept && in_item.cmd == CMD_LOAD_ISOTOPE && ei_ok && ii_ok) begin
      tab_mass[tab_waddr] <= in_item.isotope_mass;
      tab_ab[tab_waddr]   <= in_item.isotope_abundance;
    end
    tab_m_q  <= tab_mass[tab_raddr];
    tab_ab_q <= tab_ab[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mass[elem_wa] <= elem_wm;
      elem_ab[elem_wa]   <= elem_wab;
    end
    elem_m_a  <= elem_mass[elem_raddr_a];
    elem_ab_a <= elem_ab[elem_raddr_a];
    elem_m_b  <= elem_mass[elem_raddr_b];
    elem_ab_b <= elem_ab[elem_raddr_b];
  end

  always_ff @(posedge clk) begin
    if (mol_we) begin
      mol_mass[wa] <= scr_m_q;
      mol_ab[wa]   <= scr_ab_q;
    end
    mol_m_q  <= mol_mass[mol_raddr];
    mol_ab_q <= mol_ab[mol_raddr];
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mass[scr_wa] <= scr_wm;
      scr_ab[scr_wa]   <= scr_wab;
    end
    scr_m_q  <= scr_mass[scr_raddr];
    scr_ab_q <= scr_ab[scr_raddr];
  end

  // Mean-mass and charge divider.
  ipc_div_chain u_div (
    .clk    (clk),
    .rst    (rst),
    .issue  (div_in),
    .result (div_out)
  );

  // Sequencer state and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      e_cnt     <= '0;
      n_left    <= '0;
      seeded    <= 1'b0;
      trunc     <= 1'b0;
      conv_sq   <= 1'b0;
      dest_elem <= 1'b0;
      mlen      <= '0;
      elen      <= '0;
      slen      <= '0;
      cj        <= '0;
      cn        <= '0;
      wpend     <= 1'b0;
      k         <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      // Copy engine shared by the table, seed and prune copies.
      if (state == ST_TCOPY || state == ST_SCOPY || state == ST_PCOPY) begin
        if (copy_issue) begin
          cj    <= cj + LW'(1);
          wpend <= 1'b1;
          wa    <= PAW'(cj);
        end else begin
          wpend <= 1'b0;
        end
      end

      // Edge tracking of peaks above the prune limit.
      if (scr_we && scr_wab > prune_limit) begin
        if (!found) begin
          found <= 1'b1;
          first <= scr_wa;
        end
        last <= scr_wa;
      end

      // Output register: take a new item or drop the one just accepted.
      if (emit_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (accept && in_item.cmd == CMD_RUN) begin
            e_cnt  <= '0;
            seeded <= 1'b0;
            trunc  <= 1'b0;
            mlen   <= '0;
          end
        end
        ST_ELEM_START: begin
          if (e_cnt != ECW'(ELEMENTS)) begin
            if (atoms[e_sel] == '0) begin
              e_cnt <= e_cnt + ECW'(1);
            end else begin
              n_left <= atoms[e_sel];
              cj     <= '0;
              cn     <= cnt_eff;
              elen   <= cnt_eff;
              if (cnt_trunc) trunc <= 1'b1;
            end
          end
        end
        ST_BIT: begin
          dest_elem <= 1'b0;
          if (n_left[0]) begin
            conv_sq <= 1'b0;
            if (!seeded) begin
              seeded <= 1'b1;
              cj     <= '0;
              cn     <= elen;
              found  <= 1'b0;
            end
          end
        end
        ST_SQCHK: begin
          if (n_left == ATOM_W'(1)) begin
            e_cnt <= e_cnt + ECW'(1);
          end else begin
            conv_sq   <= 1'b1;
            dest_elem <= 1'b1;
          end
        end
        ST_CONV_SETUP: begin
          k     <= '0;
          found <= 1'b0;
          if (n1 == '0 || n2 == '0) begin
            slen <= '0;
          end else begin
            slen <= full_trunc ? LW'(MAX_PEAKS) : LW'(full);
            if (full_trunc) trunc <= 1'b1;
          end
        end
        ST_CONV_K: begin
          i_idx  <= lo;
          hi_idx <= hi;
          acc    <= '0;
          total  <= '0;
        end
        ST_CONV_MUL: begin
          p_q  <= prod64[63:32];
          ms_q <= msum[MASS_W] ? MASS_MAX : msum[MASS_W-1:0];
        end
        ST_CONV_MUL2: begin
          plo <= {22'b0, p_q} * {32'b0, ms_q[21:0]};
          phi <= {22'b0, p_q} * {32'b0, ms_q[43:22]};
        end
        ST_CONV_ACC: begin
          acc   <= acc_add;
          total <= total + DIV_W'(p_q);
          i_idx <= i_idx + LW'(1);
        end
        ST_CONV_DIV: begin
          if (total == '0) k <= k + LW'(1);
        end
        ST_CONV_DIVW: begin
          if (div_out.valid) k <= k + LW'(1);
        end
        ST_PSETUP: begin
          cj <= '0;
          cn <= plen;
          if (dest_elem) elen <= plen;
          else mlen <= plen;
        end
        ST_PCOPY: begin
          if (copy_done && dest_elem) n_left <= n_left >> 1;
        end
        ST_OUT_START: begin
          k <= '0;
        end
        ST_OUT_CALC: begin
          pk_ab   <= mol_ab_q;
          pk_mass <= (mol_ab_q == '0) ? '0 : mol_m_q;
        end
        ST_OUT_DIVW: begin
          if (div_out.valid) pk_mass <= adj;
        end
        ST_OUT_EMIT: begin
          if (out_free) begin
            out_item.peak_mass       <= pk_mass;
            out_item.peak_abundance  <= pk_ab;
            out_item.peak_number     <= NUM_PK_W'(k);
            out_item.run_status      <= trunc ? STATUS_TRUNC : STATUS_OK;
            out_item.last_peak       <= last_out;
            k                        <= k + LW'(1);
          end
        end
        ST_OUT_EMPTY: begin
          if (out_free) begin
            out_item.peak_mass       <= '0;
            out_item.peak_abundance  <= '0;
            out_item.peak_number     <= '0;
            out_item.run_status      <= STATUS_EMPTY;
            out_item.last_peak       <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== verif/ipc_checker.sv =====
`timescale 1ns / 100ps

// Watches the three channels of the isotope pattern convolver, predicts the
// peak list of every run item and compares each output item with it.
module ipc_checker import ipc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_item,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_item,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   errors,
  output int                   pending
);

  localparam int NEL = 8;
  localparam int NISO = 8;
  localparam int CAP = 64;

  typedef bit [MASS_W-1:0] mass_list_t [CAP];
  typedef bit [AB_W-1:0]   ab_list_t [CAP];

  // Shadow copy of the block's registers and tables.
  bit [AB_W-1:0]      limit_q;
  int                 charge_q;
  bit [MASS_W-1:0]    iso_mass [NEL][NISO];
  bit [AB_W-1:0]      iso_ab [NEL][NISO];
  bit [3:0]           iso_cnt [NEL];
  bit [ATOM_W-1:0]    atoms [NEL];
  bit                 overflowed;

  out_item_t          peak_queue [$];

  assign pending = peak_queue.size();

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Convolution of two peak lists with rounded abundance products and
  // abundance-weighted mean masses; the length is capped at CAP.
  function automatic int convolve(input mass_list_t m1, input ab_list_t a1, input int n1,
                                  input mass_list_t m2, input ab_list_t a2, input int n2,
                                  output mass_list_t rm, output ab_list_t ra);
    int len;
    int lo;
    int hi;
    bit [63:0] total;
    bit [63:0] prod;
    bit [44:0] msum;
    bit [127:0] acc;
    bit [127:0] quot;
    rm = '{default: '0};
    ra = '{default: '0};
    if (n1 == 0 || n2 == 0) return 0;
    len = n1 + n2 - 1;
    if (len > CAP) begin
      len = CAP;
      overflowed = 1'b1;
    end
    for (int k = 0; k < len; k++) begin
      lo = (k + 1 > n2) ? k + 1 - n2 : 0;
      hi = (k < n1 - 1) ? k : n1 - 1;
      total = 0;
      acc = 0;
      for (int i = lo; i <= hi; i++) begin
        prod = (64'(a1[i]) * 64'(a2[k-i]) + 64'h8000_0000) >> 32;
        if (prod != 0) begin
          msum = 45'(m1[i]) + 45'(m2[k-i]);
          if (msum > 45'(MASS_MAX)) msum = 45'(MASS_MAX);
          total += prod;
          acc += 128'(prod) * 128'(msum);
        end
      end
      if (total != 0) begin
        quot = (acc + 128'(total >> 1)) / 128'(total);
        rm[k] = (quot > 128'(MASS_MAX)) ? MASS_MAX : quot[MASS_W-1:0];
      end
      ra[k] = (total > 64'hFFFF_FFFF) ? '1 : total[31:0];
    end
    return len;
  endfunction

  // Removes edge peaks at or below the prune limit.
  function automatic int prune(inout mass_list_t m, inout ab_list_t a, input int len);
    int first;
    int last;
    first = 0;
    while (first < len && a[first] <= limit_q) first++;
    if (first == len) return 0;
    last = len - 1;
    while (a[last] <= limit_q) last--;
    for (int i = 0; i <= last - first; i++) begin
      m[i] = m[i+first];
      a[i] = a[i+first];
    end
    return last - first + 1;
  endfunction

  function automatic bit [MASS_W-1:0] charge_mass(input bit [MASS_W-1:0] m,
                                                  input bit [AB_W-1:0] ab);
    bit [MASS_W:0] z;
    bit [MASS_W:0] q;
    if (ab == 0) return '0;
    if (charge_q == 0) return m;
    z = 45'((charge_q < 0) ? -charge_q : charge_q);
    q = (45'(m) + (z >> 1)) / z;
    if (charge_q > 0) return (q > 45'(ELECTRON_Q24)) ? 44'(q - 45'(ELECTRON_Q24)) : '0;
    q += 45'(ELECTRON_Q24);
    return (q > 45'(MASS_MAX)) ? MASS_MAX : q[MASS_W-1:0];
  endfunction

  // Builds the molecule's peak list by square-and-multiply and queues its items.
  task automatic predict_peaks();
    mass_list_t mol_m, el_m, tmp_m;
    ab_list_t   mol_a, el_a, tmp_a;
    int         mol_n;
    int         el_n;
    bit         started;
    bit [ATOM_W-1:0] n;
    out_item_t  pk;
    mol_m = '{default: '0};
    mol_a = '{default: '0};
    el_m = '{default: '0};
    el_a = '{default: '0};
    mol_n = 0;
    started = 1'b0;
    overflowed = 1'b0;
    for (int e = 0; e < NEL; e++) begin
      n = atoms[e];
      if (n != 0) begin
        el_n = int'(iso_cnt[e]);
        for (int i = 0; i < el_n; i++) begin
          el_m[i] = iso_mass[e][i];
          el_a[i] = iso_ab[e][i];
        end
        forever begin
          if (n[0]) begin
            if (started) begin
              mol_n = convolve(mol_m, mol_a, mol_n, el_m, el_a, el_n, tmp_m, tmp_a);
              mol_m = tmp_m;
              mol_a = tmp_a;
            end else begin
              mol_m = el_m;
              mol_a = el_a;
              mol_n = el_n;
              started = 1'b1;
            end
            mol_n = prune(mol_m, mol_a, mol_n);
          end
          if (n == 1) break;
          el_n = convolve(el_m, el_a, el_n, el_m, el_a, el_n, tmp_m, tmp_a);
          el_m = tmp_m;
          el_a = tmp_a;
          el_n = prune(el_m, el_a, el_n);
          n >>= 1;
        end
      end
    end
    if (mol_n == 0) begin
      pk = '0;
      pk.run_status = STATUS_EMPTY;
      pk.last_peak = 1'b1;
      peak_queue.insert(peak_queue.size(), pk);
    end else begin
      for (int k = 0; k < mol_n; k++) begin
        pk.peak_mass = charge_mass(mol_m[k], mol_a[k]);
        pk.peak_abundance = mol_a[k];
        pk.peak_number = NUM_PK_W'(k);
        pk.run_status = overflowed ? STATUS_TRUNC : STATUS_OK;
        pk.last_peak = (k + 1 == mol_n);
        peak_queue.insert(peak_queue.size(), pk);
      end
    end
  endtask

  // Register writes, input items and output items, all sampled at the edge.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      limit_q <= 32'd429497;
      charge_q <= 0;
      for (int e = 0; e < NEL; e++) begin
        iso_cnt[e] = '0;
        atoms[e] = '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PRUNE_LIMIT) limit_q <= cfg_data;
        else if (cfg_index == REG_CHARGE) charge_q <= $signed(cfg_data[4:0]);
      end
      if (in_valid && !in_stall) begin
        case (in_item.cmd)
          CMD_LOAD_ISOTOPE: begin
            iso_mass[in_item.element_index][in_item.isotope_index] = in_item.isotope_mass;
            iso_ab[in_item.element_index][in_item.isotope_index] = in_item.isotope_abundance;
          end
          CMD_LOAD_ELEMENT: begin
            atoms[in_item.element_index] = in_item.atom_count;
            iso_cnt[in_item.element_index] =
              (in_item.isotope_count > NISO) ? 4'(NISO) : in_item.isotope_count;
          end
          CMD_RUN: predict_peaks();
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (peak_queue.size() == 0) begin
          report_mismatch("output item with no peak expected");
        end else begin
          want = peak_queue.pop_front();
          if (out_item.peak_mass !== want.peak_mass)
            report_mismatch($sformatf("peak_mass %h, want %h", out_item.peak_mass,
                                      want.peak_mass));
          if (out_item.peak_abundance !== want.peak_abundance)
            report_mismatch($sformatf("peak_abundance %h, want %h", out_item.peak_abundance,
                                      want.peak_abundance));
          if (out_item.peak_number !== want.peak_number)
            report_mismatch($sformatf("peak_number %0d, want %0d", out_item.peak_number,
                                      want.peak_number));
          if (out_item.run_status !== want.run_status)
            report_mismatch($sformatf("run_status %0d, want %0d", out_item.run_status,
                                      want.run_status));
          if (out_item.last_peak !== want.last_peak)
            report_mismatch($sformatf("last_peak %b, want %b", out_item.last_peak,
                                      want.last_peak));
        end
      end
    end
  end

  initial errors = 0;

endmodule

// ===== verif/isotope_pattern_convolver_tb.sv =====
`timescale 1ns / 100ps

module isotope_pattern_convolver_tb;
  import ipc_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  int                   errors;
  int                   pending;

  // Handshake flags captured at the rising edge, read at the falling edge.
  logic in_taken;
  logic cfg_taken;
  bit   gaps_on;
  int   hold_cycles;
  int   items_sent;
  bit   written [8][8];

  isotope_pattern_convolver dut (.*);

  ipc_checker checker_i (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    cfg_taken <= cfg_valid && cfg_ready;
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall = 1'b1;
        hold_cycles--;
      end else begin
        out_stall = gaps_on && ($urandom_range(99) < 19);
      end
    end
  end

  task automatic send(input in_item_t it);
    if (gaps_on && $urandom_range(99) < 19) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    do @(negedge clk); while (!in_taken);
    items_sent++;
    if (it.cmd == CMD_LOAD_ISOTOPE) written[it.element_index][it.isotope_index] = 1'b1;
  endtask

  task automatic load_isotope(input int e, input int i, input logic [MASS_W-1:0] m,
                              input logic [AB_W-1:0] a);
    in_item_t it;
    it = '0;
    it.cmd = CMD_LOAD_ISOTOPE;
    it.element_index = 3'(e);
    it.isotope_index = 3'(i);
    it.isotope_mass = m;
    it.isotope_abundance = a;
    send(it);
  endtask

  // Element counts; isotope entries that a run would read are loaded first.
  task automatic load_element(input int e, input int n, input int cnt);
    in_item_t it;
    int used;
    used = (cnt > 8) ? 8 : cnt;
    if (n != 0)
      for (int i = 0; i < used; i++)
        if (!written[e][i])
          load_isotope(e, i, 44'({$urandom, $urandom} & 64'h00F_FFFF_FFFF), $urandom);
    it = '0;
    it.cmd = CMD_LOAD_ELEMENT;
    it.element_index = 3'(e);
    it.atom_count = ATOM_W'(n);
    it.isotope_count = 4'(cnt);
    send(it);
  endtask

  task automatic run_molecule();
    in_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom};
    it.cmd = CMD_RUN;
    send(it);
  endtask

  // Waits until the block is idle, then writes one register.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (50) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid = 1'b0;
  endtask

  task automatic set_charge(input int z);
    write_reg(REG_CHARGE, {27'd0, 5'(z)});
  endtask

  // One burst of random items: mostly well-formed load-and-run sequences.
  task automatic random_burst(input int count);
    in_item_t it;
    int e;
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(99) < 70) begin
        e = $urandom_range(7);
        repeat ($urandom_range(1, 3))
          load_isotope(e, $urandom_range(7),
                       $urandom_range(1) ? 44'({$urandom, $urandom}) :
                                           44'($urandom_range(200)) << 24,
                       $urandom);
        if ($urandom_range(3) == 0) load_element(e, $urandom_range(1, 2), $urandom_range(4, 15));
        else load_element(e, $urandom_range(0, 12), $urandom_range(0, 3));
        run_molecule();
      end else begin
        it = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(2))
          0: it.cmd = 2'd3;
          1: it.cmd = CMD_LOAD_ISOTOPE;
          default: begin
            it.cmd = CMD_LOAD_ELEMENT;
            it.atom_count = '0;
          end
        endcase
        send(it);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gaps_on = 1'b0;
    hold_cycles = 0;
    items_sent = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed part: empty molecule, carbon and hydrogen, and the extremes.
    run_molecule();
    load_isotope(0, 0, 44'd12 << 24, 32'(longint'(0.9893 * 4294967296.0)));
    load_isotope(0, 1, 44'(longint'(13.0033548 * 16777216.0)),
                 32'(longint'(0.0107 * 4294967296.0)));
    load_isotope(1, 0, 44'(longint'(1.0078250 * 16777216.0)),
                 32'(longint'(0.999885 * 4294967296.0)));
    load_isotope(1, 1, 44'(longint'(2.0141018 * 16777216.0)),
                 32'(longint'(0.000115 * 4294967296.0)));
    load_element(0, 6, 2);
    load_element(1, 12, 2);
    run_molecule();
    // Saturating mass sums with the largest atom count.
    load_isotope(2, 0, MASS_MAX, '1);
    load_element(2, 20'hFFFFF, 1);
    run_molecule();
    set_charge(1);
    run_molecule();
    // Truncation: all eight slots of the last element, a count that saturates.
    for (int i = 0; i < 8; i++) load_isotope(7, i, 44'(i + 1) << 24, '1);
    load_element(0, 0, 0);
    load_element(1, 0, 0);
    load_element(2, 0, 0);
    load_element(7, 16, 15);
    write_reg(REG_PRUNE_LIMIT, 32'd0);
    run_molecule();
    load_element(7, 0, 8);
    send('{cmd: 2'd3, default: '0});
    write_reg(2'd3, '1);

    // Random phases under different settings, with idling switched on.
    gaps_on = 1'b1;
    write_reg(REG_PRUNE_LIMIT, 32'd429497);
    set_charge(-16);
    random_burst(15);
    write_reg(REG_PRUNE_LIMIT, '1);
    set_charge(15);
    random_burst(8);
    write_reg(REG_PRUNE_LIMIT, 32'd0);
    set_charge(-1);
    // Receiver holds off while the sender keeps offering items.
    hold_cycles = 400;
    random_burst(10);
    write_reg(REG_PRUNE_LIMIT, $urandom_range(32'h0FFF_FFFF));
    set_charge($urandom_range(30) - 15);
    random_burst(15);
    // A stretch with no idling on either side.
    gaps_on = 1'b0;
    set_charge(0);
    random_burst(15);
    gaps_on = 1'b1;
    write_reg(REG_PRUNE_LIMIT, $urandom);
    set_charge(-15);
    random_burst(12);

    in_valid = 1'b0;
    wait (pending == 0);
    repeat (500) @(negedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2_000_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ipc_pkg.sv
sv/ipc_div_cell.sv
sv/ipc_div_chain.sv
sv/isotope_pattern_convolver.sv
verif/ipc_checker.sv
verif/isotope_pattern_convolver_tb.sv
